>>> design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the TGA run-length decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // One result as it travels from the parser to the output stage.
    // Header and error records carry height:width in value and the
    // bytes per pixel in rep.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [7:0]  rep;
        logic        last;
    } t_rec;

endpackage

>>> design/trd_parser.sv
// ----------------------------------------------------------------------------
// trd_parser
// Front end: walks the header, skips ID and color map, decodes packets and
// gathers pixels, producing one result record per byte at most.
// ----------------------------------------------------------------------------
module trd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_start_of_file,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output trd_pkg::t_rec o_rec
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_RAW    = 3'd2;
    localparam logic [2:0] PH_HEAD   = 3'd3;
    localparam logic [2:0] PH_PACKET = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_TYPE     = 5'd2;
    localparam logic [4:0] HDR_MAP_LO   = 5'd5;
    localparam logic [4:0] HDR_MAP_HI   = 5'd6;
    localparam logic [4:0] HDR_MAP_BITS = 5'd7;
    localparam logic [4:0] HDR_W_LO     = 5'd12;
    localparam logic [4:0] HDR_W_HI     = 5'd13;
    localparam logic [4:0] HDR_H_LO     = 5'd14;
    localparam logic [4:0] HDR_H_HI     = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_LAST     = 5'd17;

    localparam logic [7:0]  TYPE_RAW = 8'd2;
    localparam logic [7:0]  TYPE_RLE = 8'd10;
    localparam logic [17:0] SKIP_MAX = 18'h3FFFF;

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_hpos, n_hpos;
    logic [7:0]  r_type, n_type;
    logic [17:0] r_skip, n_skip;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [2:0]  r_bpp, n_bpp;
    logic [31:0] r_pleft, n_pleft;
    logic [7:0]  r_pkleft, n_pkleft;
    logic        r_isrun, n_isrun;
    logic [1:0]  r_bip, n_bip;
    logic [31:0] r_acc, n_acc;

    logic          fire;
    logic [5:0]    entry_bytes;
    logic [21:0]   map_bytes;
    logic [22:0]   skip_total;
    logic [31:0]   area;
    logic [4:0]    depth_bytes;
    logic [31:0]   g_acc;
    logic [1:0]    g_bip;
    logic          g_done;
    logic [7:0]    run_rep;
    logic [7:0]    rep;
    logic          push;
    trd_pkg::t_rec rec;

    assign fire    = i_valid && !i_full;
    assign o_ready = !i_full;

    // Color map size: length times whole bytes per entry, saturated.
    assign entry_bytes = 6'(({1'b0, i_data_byte} + 9'd7) >> 3);
    assign map_bytes   = r_acc[15:0] * entry_bytes;
    assign skip_total  = 23'(r_skip) + 23'(map_bytes);
    assign area        = r_width * r_height;
    assign depth_bytes = i_data_byte[7:3];

    always_comb begin
        g_acc = r_acc;
        case (r_bip)
            2'd0:    g_acc[7:0]   = r_acc[7:0]   | i_data_byte;
            2'd1:    g_acc[15:8]  = r_acc[15:8]  | i_data_byte;
            2'd2:    g_acc[23:16] = r_acc[23:16] | i_data_byte;
            default: g_acc[31:24] = r_acc[31:24] | i_data_byte;
        endcase
    end

    assign g_bip   = r_bip + 2'd1;
    assign g_done  = (g_bip == 2'd0) || ({1'b0, g_bip} >= r_bpp);
    assign run_rep = ({24'd0, r_pkleft} < r_pleft) ? r_pkleft : r_pleft[7:0];

    always_comb begin
        n_phase  = r_phase;
        n_hpos   = r_hpos;
        n_type   = r_type;
        n_skip   = r_skip;
        n_width  = r_width;
        n_height = r_height;
        n_bpp    = r_bpp;
        n_pleft  = r_pleft;
        n_pkleft = r_pkleft;
        n_isrun  = r_isrun;
        n_bip    = r_bip;
        n_acc    = r_acc;
        push     = 1'b0;
        rec      = '0;
        rep      = 8'd0;
        if (fire) begin
            if (i_start_of_file) begin
                n_phase  = PH_HEADER;
                n_hpos   = '0;
                n_type   = '0;
                n_skip   = '0;
                n_width  = '0;
                n_height = '0;
                n_bpp    = '0;
                n_pleft  = '0;
                n_pkleft = '0;
                n_isrun  = 1'b0;
                n_bip    = '0;
                n_acc    = '0;
            end
            unique case (n_phase)
                PH_HEADER: begin
                    case (n_hpos)
                        HDR_ID_LEN:   n_skip = {10'd0, i_data_byte};
                        HDR_MAP_TYPE: n_acc[16] = (i_data_byte != 8'd0);
                        HDR_TYPE:     n_type = i_data_byte;
                        HDR_MAP_LO:   n_acc[7:0] = i_data_byte;
                        HDR_MAP_HI:   n_acc[15:8] = i_data_byte;
                        HDR_MAP_BITS: begin
                            if (r_acc[16]) begin
                                n_skip = (skip_total > 23'(SKIP_MAX)) ? SKIP_MAX
                                                                      : skip_total[17:0];
                            end
                            n_acc = '0;
                        end
                        HDR_W_LO:  n_width[7:0]   = i_data_byte;
                        HDR_W_HI:  n_width[15:8]  = i_data_byte;
                        HDR_H_LO:  n_height[7:0]  = i_data_byte;
                        HDR_H_HI:  n_height[15:8] = i_data_byte;
                        HDR_DEPTH: n_bpp = (depth_bytes <= 5'd4) ? depth_bytes[2:0] : 3'd0;
                        default: ;
                    endcase
                    if (n_hpos >= HDR_LAST) begin
                        n_pleft   = area;
                        push      = 1'b1;
                        rec.value = {n_height, n_width};
                        rec.rep   = {5'd0, n_bpp};
                        if (!((n_type == TYPE_RAW || n_type == TYPE_RLE) && n_bpp != 3'd0)) begin
                            rec.kind = trd_pkg::KIND_ERROR;
                            n_phase  = PH_DONE;
                        end else begin
                            rec.kind = trd_pkg::KIND_HEADER;
                            if (n_skip != '0) begin
                                n_phase = PH_SKIP;
                            end else begin
                                n_bip = '0;
                                n_acc = '0;
                                if (area == 32'd0) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = (n_type == TYPE_RAW) ? PH_RAW : PH_HEAD;
                                end
                            end
                        end
                    end else begin
                        n_hpos = n_hpos + 5'd1;
                    end
                end
                PH_SKIP: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 18'd1;
                    end
                    if (n_skip == '0) begin
                        n_bip = '0;
                        n_acc = '0;
                        if (r_pleft == 32'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = (r_type == TYPE_RAW) ? PH_RAW : PH_HEAD;
                        end
                    end
                end
                PH_RAW: begin
                    n_acc = g_acc;
                    n_bip = g_bip;
                    if (g_done) begin
                        n_acc     = '0;
                        n_bip     = '0;
                        n_pleft   = r_pleft - 32'd1;
                        push      = 1'b1;
                        rec.kind  = trd_pkg::KIND_PIXEL;
                        rec.value = g_acc;
                        rec.rep   = 8'd1;
                        rec.last  = (n_pleft == 32'd0);
                        if (n_pleft == 32'd0) begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_HEAD: begin
                    n_isrun  = i_data_byte[7];
                    n_pkleft = {1'b0, i_data_byte[6:0]} + 8'd1;
                    n_bip    = '0;
                    n_acc    = '0;
                    n_phase  = PH_PACKET;
                end
                PH_PACKET: begin
                    n_acc = g_acc;
                    n_bip = g_bip;
                    if (g_done) begin
                        n_acc = '0;
                        n_bip = '0;
                        if (r_isrun) begin
                            rep      = run_rep;
                            n_pkleft = '0;
                        end else begin
                            rep      = 8'd1;
                            n_pkleft = r_pkleft - 8'd1;
                        end
                        n_pleft   = r_pleft - 32'(rep);
                        push      = 1'b1;
                        rec.kind  = trd_pkg::KIND_PIXEL;
                        rec.value = g_acc;
                        rec.rep   = rep;
                        rec.last  = (n_pleft == 32'd0);
                        if (n_pleft == 32'd0) begin
                            n_phase = PH_DONE;
                        end else if (n_pkleft == 8'd0) begin
                            n_phase = PH_HEAD;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hpos   <= '0;
            r_type   <= '0;
            r_skip   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bpp    <= '0;
            r_pleft  <= '0;
            r_pkleft <= '0;
            r_isrun  <= 1'b0;
            r_bip    <= '0;
            r_acc    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_hpos   <= n_hpos;
            r_type   <= n_type;
            r_skip   <= n_skip;
            r_width  <= n_width;
            r_height <= n_height;
            r_bpp    <= n_bpp;
            r_pleft  <= n_pleft;
            r_pkleft <= n_pkleft;
            r_isrun  <= n_isrun;
            r_bip    <= n_bip;
            r_acc    <= n_acc;
        end
    end

    assign o_push = push;
    assign o_rec  = rec;

endmodule

>>> design/trd_queue.sv
// ----------------------------------------------------------------------------
// trd_queue
// Small first-in first-out buffer of result records between parser and
// output stage.
// ----------------------------------------------------------------------------
module trd_queue #(
    parameter int DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trd_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output trd_pkg::t_rec o_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    trd_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

endmodule

>>> design/trd_output.sv
// ----------------------------------------------------------------------------
// trd_output
// Back end: takes records from the queue into the output register, keeps
// the header values of the current image and attaches them to every result.
// ----------------------------------------------------------------------------
module trd_output (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  trd_pkg::t_rec i_rec,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [1:0]    o_kind,
    output logic [31:0]   o_pixel_value,
    output logic [7:0]    o_repeat_count,
    output logic [15:0]   o_pic_width,
    output logic [15:0]   o_pic_height,
    output logic [2:0]    o_pixel_bytes,
    output logic          o_last
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [31:0] r_value;
    logic [7:0]  r_rep;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [2:0]  r_bpp;
    logic        r_last;
    logic        pop;

    assign pop   = i_q_valid && (!r_valid || i_ready);
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Header and error records refresh the image values; pixel runs reuse them.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind <= i_rec.kind;
            r_last <= i_rec.last;
            if (i_rec.kind == trd_pkg::KIND_PIXEL) begin
                r_value <= i_rec.value;
                r_rep   <= i_rec.rep;
            end else begin
                r_value  <= '0;
                r_rep    <= '0;
                r_width  <= i_rec.value[15:0];
                r_height <= i_rec.value[31:16];
                r_bpp    <= i_rec.rep[2:0];
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_pixel_value  = r_value;
    assign o_repeat_count = r_rep;
    assign o_pic_width    = r_width;
    assign o_pic_height   = r_height;
    assign o_pixel_bytes  = r_bpp;
    assign o_last         = r_last;

endmodule

>>> design/tga_rle_image_decoder_top.sv
// A result is held in the record queue, then in the output register, before it is valid.
// Throughput: one file byte per cycle, while the record queue has room.
// The queue depth and the single output register set how long either side may stall.
// Reset (synchronous, active low) returns the parser to header byte 0 and empties
// the queue and the output register.
// ----------------------------------------------------------------------------
// tga_rle_image_decoder_top
// Byte-serial TGA decoder: header, ID/color-map skip, raw and RLE pixel runs.
// ----------------------------------------------------------------------------
module tga_rle_image_decoder_top #(
    parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_pixel_value,
    output logic [7:0]  o_repeat_count,
    output logic [15:0] o_pic_width,
    output logic [15:0] o_pic_height,
    output logic [2:0]  o_pixel_bytes,
    output logic        o_last
);

    logic          push;
    logic          full;
    logic          q_valid;
    logic          pop;
    trd_pkg::t_rec push_rec;
    trd_pkg::t_rec head_rec;

    trd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_full          (full),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_rec           (push_rec)
    );

    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    trd_output u_output (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_rec          (head_rec),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_pixel_value  (o_pixel_value),
        .o_repeat_count (o_repeat_count),
        .o_pic_width    (o_pic_width),
        .o_pic_height   (o_pic_height),
        .o_pixel_bytes  (o_pixel_bytes),
        .o_last         (o_last)
    );

endmodule

>>> design/trd_checker.sv
// ----------------------------------------------------------------------------
// trd_checker
// Port-level checks of the TGA decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_start_of_file,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_pixel_value,
    input logic [7:0]  o_repeat_count,
    input logic [15:0] o_pic_width,
    input logic [15:0] o_pic_height,
    input logic [2:0]  o_pixel_bytes,
    input logic        o_last
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "output beat dropped")
    `ASSERT_SAME(a_run_count, i_clk, i_rst_n, o_valid && o_kind == trd_pkg::KIND_PIXEL, o_repeat_count != 8'd0 && o_repeat_count <= 8'd128, "pixel run count out of range")
    `ASSERT_SAME(a_info_clean, i_clk, i_rst_n, o_valid && o_kind != trd_pkg::KIND_PIXEL, o_pixel_value == 32'd0 && o_repeat_count == 8'd0 && !o_last, "header or error beat carries pixel data")
    `ASSERT_SAME(a_header_depth, i_clk, i_rst_n, o_valid && o_kind == trd_pkg::KIND_HEADER, o_pixel_bytes != 3'd0 && o_pixel_bytes <= 3'd4, "accepted header with bad pixel depth")

endmodule

bind tga_rle_image_decoder_top trd_checker u_trd_checker (.*);
